### design/jvmp_pkg.sv
// Package: shared widths, payload structs, register indexes and the CORDIC arctangent table.
package jvmp_pkg;

	localparam int COMP_W       = 16;
	localparam int IW           = COMP_W + 3;
	localparam int COEF_W       = 30;
	localparam int Z_W          = 33;
	localparam int CORDIC_STEPS = 30;
	localparam int DOCP_W       = 16;
	localparam int DIV_STEPS    = DOCP_W + 1;
	localparam int DEN_W        = 2 * DOCP_W + 1;
	localparam int NUM_W        = 2 * DOCP_W + DOCP_W + 1;
	localparam int NSLOT        = 8;
	localparam logic signed [Z_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [1:0] REG_FIRST_ROT  = 2'd0;
	localparam logic [1:0] REG_FIRST_RET  = 2'd1;
	localparam logic [1:0] REG_SECOND_ROT = 2'd2;
	localparam logic [1:0] REG_SECOND_RET = 2'd3;

	typedef struct packed {
		logic                     mode;
		logic signed [COMP_W-1:0] in_x_re;
		logic signed [COMP_W-1:0] in_x_im;
		logic signed [COMP_W-1:0] in_y_re;
		logic signed [COMP_W-1:0] in_y_im;
	} in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_x_re;
		logic signed [COMP_W-1:0] out_x_im;
		logic signed [COMP_W-1:0] out_y_re;
		logic signed [COMP_W-1:0] out_y_im;
		logic signed [DOCP_W-1:0] circ_degree;
		logic                     zero_vector;
	} out_t;

	typedef struct packed {
		logic                 mode;
		logic signed [IW-1:0] xr;
		logic signed [IW-1:0] xi;
		logic signed [IW-1:0] yr;
		logic signed [IW-1:0] yi;
	} wvec_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] s;
	} coef_t;

	function automatic logic [29:0] atan_lut(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

### design/jvmp_coef.sv
// Configuration registers and iterative CORDIC that builds the eight cos/sin coefficient pairs.
module jvmp_coef #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [ANGLE_BITS-1:0] cfg_data,
	output logic                  coef_ready,
	output jvmp_pkg::coef_t       coef_q [jvmp_pkg::NSLOT]
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	localparam int ZW = jvmp_pkg::Z_W;

	state_t                state_q;
	logic [2:0]            slot_q;
	logic [4:0]            step_q;
	logic [ANGLE_BITS-1:0] rot1_q, ret1_q, rot2_q, ret2_q;
	logic signed [ZW-1:0]  x_q, y_q, z_q;
	logic                  flip_q;

	logic signed [ZW-1:0]  ang_z, fold_z, dx, dy, atan_v, xf, yf, cr, sr;
	logic                  fold_flip;
	logic [4:0]            iter;

	function automatic logic signed [ZW-1:0] to_z(input logic [ANGLE_BITS-1:0] r,
		input logic neg, input logic half);
		logic signed [ANGLE_BITS:0] v;
		logic [63:0]                t;
		v = {r[ANGLE_BITS-1], r};
		if (neg) begin
			v = -v;
		end
		t = 64'(signed'(v));
		if (half) begin
			t = t << (31 - ANGLE_BITS);
		end else begin
			t = t << (32 - ANGLE_BITS);
		end
		return {t[31], t[31:0]};
	endfunction

	assign cfg_ready  = (state_q == ST_IDLE);
	assign coef_ready = (state_q == ST_IDLE);

	// slots 0..3 serve forward stages, 4..7 backward stages
	always_comb begin
		case (slot_q)
			3'd0: ang_z = to_z(rot1_q, 1'b0, 1'b0);
			3'd1: ang_z = to_z(ret1_q, 1'b0, 1'b1);
			3'd2: ang_z = to_z(rot2_q, 1'b0, 1'b0);
			3'd3: ang_z = to_z(ret2_q, 1'b0, 1'b1);
			3'd4: ang_z = to_z(ret2_q, 1'b1, 1'b1);
			3'd5: ang_z = to_z(rot2_q, 1'b1, 1'b0);
			3'd6: ang_z = to_z(ret1_q, 1'b1, 1'b1);
			3'd7: ang_z = to_z(rot1_q, 1'b1, 1'b0);
			default: ang_z = '0;
		endcase
	end

	// fold into [-pi/2, pi/2]
	always_comb begin
		fold_z    = ang_z;
		fold_flip = 1'b0;
		if (ang_z > (ZW'(1) <<< 30)) begin
			fold_z    = ang_z - (ZW'(1) <<< 31);
			fold_flip = 1'b1;
		end else if (ang_z < -(ZW'(1) <<< 30)) begin
			fold_z    = ang_z + (ZW'(1) <<< 31);
			fold_flip = 1'b1;
		end
	end

	assign iter   = step_q - 5'd1;
	assign dx     = y_q >>> iter;
	assign dy     = x_q >>> iter;
	assign atan_v = ZW'(jvmp_pkg::atan_lut(iter));
	assign xf     = flip_q ? -x_q : x_q;
	assign yf     = flip_q ? -y_q : y_q;
	assign cr     = (xf + ZW'(2)) >>> 2;
	assign sr     = (yf + ZW'(2)) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			slot_q  <= '0;
			step_q  <= '0;
			rot1_q  <= '0;
			ret1_q  <= '0;
			rot2_q  <= '0;
			ret2_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							jvmp_pkg::REG_FIRST_ROT:  rot1_q <= cfg_data;
							jvmp_pkg::REG_FIRST_RET:  ret1_q <= cfg_data;
							jvmp_pkg::REG_SECOND_ROT: rot2_q <= cfg_data;
							jvmp_pkg::REG_SECOND_RET: ret2_q <= cfg_data;
							default: ;
						endcase
						state_q <= ST_RUN;
						slot_q  <= '0;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						slot_q <= slot_q + 3'd1;
						if (slot_q == 3'(jvmp_pkg::NSLOT - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// CORDIC datapath: load, thirty micro-rotations, then round and store
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			if (step_q == 5'd0) begin
				x_q    <= jvmp_pkg::CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= fold_z;
				flip_q <= fold_flip;
			end else if (step_q == 5'd31) begin
				coef_q[slot_q].c <= cr[jvmp_pkg::COEF_W-1:0];
				coef_q[slot_q].s <= sr[jvmp_pkg::COEF_W-1:0];
			end else if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
	end

endmodule

### design/jvmp_xform.sv
// One pipelined rotation or phase-shift stage on a wide Jones vector.
module jvmp_xform (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  jvmp_pkg::wvec_t       d_in,
	input  logic                  rot,
	input  jvmp_pkg::coef_t       coef,
	output logic                  v_s,
	output jvmp_pkg::wvec_t       d_s
);

	localparam int IW = jvmp_pkg::IW;
	localparam int CW = jvmp_pkg::COEF_W;

	jvmp_pkg::wvec_t nxt;

	function automatic logic signed [IW-1:0] mac(input logic signed [IW-1:0] a,
		input logic signed [IW-1:0] b, input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] s, input logic sub);
		logic signed [IW+CW-1:0] pa, pb;
		logic signed [IW+CW:0]   acc;
		pa  = a * c;
		pb  = b * s;
		if (sub) begin
			acc = (IW+CW+1)'(pa) - (IW+CW+1)'(pb);
		end else begin
			acc = (IW+CW+1)'(pa) + (IW+CW+1)'(pb);
		end
		acc = acc + ((IW+CW+1)'(1) <<< 27);
		return acc[27+IW:28];
	endfunction

	always_comb begin
		nxt.mode = d_in.mode;
		if (rot) begin
			nxt.xr = mac(d_in.xr, d_in.yr, coef.c, coef.s, 1'b0);
			nxt.xi = mac(d_in.xi, d_in.yi, coef.c, coef.s, 1'b0);
			nxt.yr = mac(d_in.yr, d_in.xr, coef.c, coef.s, 1'b1);
			nxt.yi = mac(d_in.yi, d_in.xi, coef.c, coef.s, 1'b1);
		end else begin
			nxt.xr = mac(d_in.xr, d_in.xi, coef.c, coef.s, 1'b1);
			nxt.xi = mac(d_in.xi, d_in.xr, coef.c, coef.s, 1'b0);
			nxt.yr = mac(d_in.yr, d_in.yi, coef.c, coef.s, 1'b0);
			nxt.yi = mac(d_in.yi, d_in.yr, coef.c, coef.s, 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (en) begin
			v_s <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= nxt;
		end
	end

endmodule

### design/jvmp_docp.sv
// Saturation, circular-degree products and a pipelined restoring divider.
module jvmp_docp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  jvmp_pkg::wvec_t d_in,
	output logic            v_out,
	output jvmp_pkg::out_t  d_out
);

	localparam int CB = jvmp_pkg::COMP_W;
	localparam int IW = jvmp_pkg::IW;
	localparam int NS = jvmp_pkg::DIV_STEPS;
	localparam int DW = jvmp_pkg::DEN_W;
	localparam int NW = jvmp_pkg::NUM_W;
	localparam int QW = jvmp_pkg::DOCP_W;

	typedef struct packed {
		logic signed [CB-1:0] a, b, c, d;
	} parts_t;

	typedef struct packed {
		parts_t               p;
		logic signed [2*CB-1:0] ad, bc, aa, bb, cc, dd;
	} prod_t;

	typedef struct packed {
		parts_t     p;
		logic       neg;
		logic       zero;
		logic [DW-1:0] den;
		logic [NW-1:0] rem;
		logic [NS-1:0] q;
	} div_t;

	function automatic logic signed [CB-1:0] sat(input logic signed [IW-1:0] v);
		logic signed [CB-1:0] r;
		if (v > IW'((1 <<< (CB - 1)) - 1)) begin
			r = {1'b0, {(CB-1){1'b1}}};
		end else if (v < -(IW'(1) <<< (CB - 1))) begin
			r = {1'b1, {(CB-1){1'b0}}};
		end else begin
			r = v[CB-1:0];
		end
		return r;
	endfunction

	logic          v_s1, v_s2;
	prod_t         prod_s1;
	div_t          div_s2;
	logic          dv_s [NS];
	div_t          dstg_s [NS];
	parts_t        sp;
	logic signed [2*CB:0] n_w;
	logic [2*CB-1:0]      absn;
	logic [DW-1:0]        den_w;
	logic [NS-1:0]        qf;
	logic [QW-1:0]        mag;

	always_comb begin
		sp.a = sat(d_in.xr);
		sp.b = sat(d_in.xi);
		sp.c = sat(d_in.yr);
		sp.d = sat(d_in.yi);
	end

	assign n_w   = (2*CB+1)'(prod_s1.ad) - (2*CB+1)'(prod_s1.bc);
	assign absn  = n_w[2*CB] ? (2*CB)'(-n_w) : n_w[2*CB-1:0];
	assign den_w = DW'(unsigned'(prod_s1.aa)) + DW'(unsigned'(prod_s1.bb))
		+ DW'(unsigned'(prod_s1.cc)) + DW'(unsigned'(prod_s1.dd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.p  <= sp;
			prod_s1.ad <= sp.a * sp.d;
			prod_s1.bc <= sp.b * sp.c;
			prod_s1.aa <= sp.a * sp.a;
			prod_s1.bb <= sp.b * sp.b;
			prod_s1.cc <= sp.c * sp.c;
			prod_s1.dd <= sp.d * sp.d;
			div_s2.p    <= prod_s1.p;
			div_s2.neg  <= n_w[2*CB];
			div_s2.zero <= (prod_s1.p == '0);
			div_s2.den  <= den_w;
			// numerator: |2N| * 32768 plus half the denominator for rounding
			div_s2.rem  <= (NW'(absn) << QW) + NW'(den_w >> 1);
			div_s2.q    <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < NS; j++) begin : g_div
		localparam int K = NS - 1 - j;
		div_t          src;
		div_t          nxt;
		logic          vsrc;
		logic [NW-1:0] sh;
		if (j == 0) begin : g_first
			assign src  = div_s2;
			assign vsrc = v_s2;
		end else begin : g_next
			assign src  = dstg_s[j-1];
			assign vsrc = dv_s[j-1];
		end
		assign sh = NW'(src.den) << K;

		always_comb begin
			nxt = src;
			if (src.rem >= sh) begin
				nxt.rem  = src.rem - sh;
				nxt.q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (en) begin
				dv_s[j] <= vsrc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dstg_s[j] <= nxt;
			end
		end
	end

	// clamp a full-scale magnitude to the largest positive value
	assign qf  = dstg_s[NS-1].q;
	assign mag = (qf[NS-1:QW-1] != '0) ? {1'b0, {(QW-1){1'b1}}} : qf[QW-1:0];

	assign v_out = dv_s[NS-1];
	always_comb begin
		d_out.out_x_re    = dstg_s[NS-1].p.a;
		d_out.out_x_im    = dstg_s[NS-1].p.b;
		d_out.out_y_re    = dstg_s[NS-1].p.c;
		d_out.out_y_im    = dstg_s[NS-1].p.d;
		d_out.zero_vector = dstg_s[NS-1].zero;
		if (dstg_s[NS-1].zero) begin
			d_out.circ_degree = '0;
		end else if (dstg_s[NS-1].neg) begin
			d_out.circ_degree = -mag;
		end else begin
			d_out.circ_degree = mag;
		end
	end

endmodule

### design/jones_vector_mirror_propagation.sv
// Top level: Jones vector propagation through two mirrors with circular degree output.
//
// Usage
//   in channel  : in_valid/in_ready carry one request (mode, x and y components, Q1.15).
//   out channel : out_valid/out_ready carry the propagated vector, saturated to Q1.15,
//                 the degree of circular polarization and the zero-vector flag.
//   cfg channel : cfg_valid/cfg_ready write one angle register selected by cfg_index.
// Timing
//   From acceptance to out_valid a request passes four transform stages, two
//   stages of saturation and products, and seventeen divider stages, one quotient
//   bit each. Barring stalls and coefficient passes, one request is taken per cycle.
// Configuration
//   Each register write starts the coefficient CORDIC, which runs 30 micro-rotations
//   per angle over eight angles (forward and backward set). During that pass
//   cfg_ready and in_ready stay low. Reset clears the registers to zero and runs
//   the same pass before the first request is taken.
// Stall
//   When out_ready is low with a result waiting, the whole pipeline holds; in_ready
//   drops in that cycle so nothing is lost or repeated.
module jones_vector_mirror_propagation #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  jvmp_pkg::in_t         in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output jvmp_pkg::out_t        out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [ANGLE_BITS-1:0] cfg_data
);

	localparam int IW = jvmp_pkg::IW;

	jvmp_pkg::coef_t coef_q [jvmp_pkg::NSLOT];
	logic            coef_ready;
	logic            adv;
	logic            xv [5];
	jvmp_pkg::wvec_t xd [5];

	// advance every stage together whenever the output slot is free or drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = coef_ready && adv;

	jvmp_coef #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.coef_ready (coef_ready),
		.coef_q     (coef_q)
	);

	assign xv[0]      = in_valid && in_ready;
	assign xd[0].mode = in_data.mode;
	assign xd[0].xr   = IW'(in_data.in_x_re);
	assign xd[0].xi   = IW'(in_data.in_x_im);
	assign xd[0].yr   = IW'(in_data.in_y_re);
	assign xd[0].yi   = IW'(in_data.in_y_im);

	// forward: rotate, shift, rotate, shift; backward: shift, rotate, shift, rotate
	for (genvar k = 0; k < 4; k++) begin : g_xf
		logic            rot;
		jvmp_pkg::coef_t cf;
		assign rot = ((k % 2) == 0) ^ xd[k].mode;
		assign cf  = xd[k].mode ? coef_q[4 + k] : coef_q[k];
		jvmp_xform u_xform (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.v_in   (xv[k]),
			.d_in   (xd[k]),
			.rot    (rot),
			.coef   (cf),
			.v_s    (xv[k+1]),
			.d_s    (xd[k+1])
		);
	end

	jvmp_docp u_docp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (xv[4]),
		.d_in   (xd[4]),
		.v_out  (out_valid),
		.d_out  (out_data)
	);

`ifndef SYNTHESIS
	a_zero_circ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_vector |-> out_data.circ_degree == '0)
		else $error("zero vector with nonzero circular degree");
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
		else $error("requests taken while coefficients rebuild");
	a_circ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.circ_degree != {1'b1, {(jvmp_pkg::DOCP_W-1){1'b0}}})
		else $error("circular degree outside clamp");
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken during output stall");
`endif

endmodule
